@@ sv/sktbl_pkg.sv @@
// Shared types and codes for the sorted key table.
// No dependencies; imported by sorted_key_table_insert_lookup.
package sktbl_pkg;

    localparam int KEY_W    = 16;
    localparam int NODE_W   = 8;
    localparam int WEIGHT_W = 32;
    localparam int RECORD_W = 1 + 2 * NODE_W + WEIGHT_W;   // 49
    localparam int ENTRY_W  = KEY_W + RECORD_W;            // 65
    localparam int STATUS_W = 2;
    localparam int OUT_POS_W = 7;

    // request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // record layout: enabled, source, target, weight (weight in the low bits)
    typedef struct packed {
        logic                enabled;
        logic [NODE_W-1:0]   source;
        logic [NODE_W-1:0]   target;
        logic [WEIGHT_W-1:0] weight;
    } record_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        record_t          rec;
    } entry_t;

endpackage

@@ sv/sorted_key_table_insert_lookup.sv @@
// Sorted link table with insert and lookup, one shared compare unit.
// Depends on sktbl_pkg (types, opcodes, status codes).
//
// Usage:
//   Requests enter on in_valid/in_ready with operation, link_key and the
//   link record. operation = insert stores the record in ascending id order;
//   operation = lookup only reports. Each request yields one result on
//   out_valid/out_ready: status, present, slot_position, entry_count.
//   Entries live in one single-port-write, registered-read memory of
//   CAPACITY words. A binary search probes it with one comparator; each
//   probe issues the address in ST_PROBE, then compares the registered
//   read data in ST_CMP. An insert then moves every entry from the slot
//   upward up by one word, with a read step and a write step per moved
//   entry, and writes the new word in ST_PLACE. in_ready returns with the
//   result, so a new request is accepted only once the previous one has
//   finished. The result sits in an output register, so a new request
//   is accepted while the previous result still waits; a request that
//   finishes before that result is taken holds in its final step until
//   the register frees. Reset empties the table (count to zero); memory
//   contents are left as is and are never read above the count, so no
//   clearing pass is needed.
module sorted_key_table_insert_lookup #(
    parameter int CAPACITY = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         operation,
    input  logic [sktbl_pkg::KEY_W-1:0]    link_key,
    input  logic [sktbl_pkg::NODE_W-1:0]   source_node,
    input  logic [sktbl_pkg::NODE_W-1:0]   target_node,
    input  logic [sktbl_pkg::WEIGHT_W-1:0] link_weight,
    input  logic                         link_enabled,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sktbl_pkg::STATUS_W-1:0] status,
    output logic                         present,
    output logic [sktbl_pkg::OUT_POS_W-1:0] slot_position,
    output logic [sktbl_pkg::OUT_POS_W-1:0] entry_count
);
    import sktbl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_DONE
    } state_t;

    // table memory
    entry_t mem [CAPACITY];
    entry_t rd_data_reg;
    logic   rd_en;
    logic [AW-1:0] rd_addr;
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;

    // sequencer registers
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          eq_reg, eq_next;
    logic          op_reg, op_next;
    entry_t        req_reg, req_next;
    status_t       stat_reg, stat_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic          out_present_reg, out_present_next;
    logic [CW-1:0] out_pos_reg, out_pos_next;
    logic [CW-1:0] out_count_reg, out_count_next;

    logic [CW-1:0] mid;
    logic [CW-1:0] idx_dec;
    logic [CW+OUT_POS_W-1:0] pos_ext;
    logic [CW+OUT_POS_W-1:0] cnt_ext;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - ONE_C;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        idx_next         = idx_reg;
        eq_next          = eq_reg;
        op_next          = op_reg;
        req_next         = req_reg;
        stat_next        = stat_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        out_status_next  = out_status_reg;
        out_present_next = out_present_reg;
        out_pos_next     = out_pos_reg;
        out_count_next   = out_count_reg;
        rd_en            = 1'b0;
        rd_addr          = mid[AW-1:0];
        wr_en            = 1'b0;
        wr_addr          = idx_reg[AW-1:0];
        wr_data          = rd_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next              = operation;
                    req_next.key         = link_key;
                    req_next.rec.enabled = link_enabled;
                    req_next.rec.source  = source_node;
                    req_next.rec.target  = target_node;
                    req_next.rec.weight  = link_weight;
                    lo_next              = '0;
                    hi_next              = count_reg;
                    eq_next              = 1'b0;
                    state_next           = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    idx_next   = mid;
                    state_next = ST_CMP;
                end
                else
                begin
                    // search finished: lo is the lower-bound slot
                    idx_next = count_reg;
                    if (op_reg == OP_LOOKUP)
                    begin
                        stat_next  = STATUS_DONE;
                        state_next = ST_DONE;
                    end
                    else if (eq_reg)
                    begin
                        stat_next  = STATUS_DUPLICATE;
                        state_next = ST_DONE;
                    end
                    else if (count_reg == CAP_C)
                    begin
                        stat_next  = STATUS_FULL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        stat_next  = STATUS_DONE;
                        state_next = (count_reg > lo_reg) ? ST_SHIFT_RD : ST_PLACE;
                    end
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg.key < req_reg.key)
                begin
                    lo_next = idx_reg + ONE_C;
                end
                else
                begin
                    hi_next = idx_reg;
                    eq_next = (rd_data_reg.key == req_reg.key);
                end
                state_next = ST_PROBE;
            end
            ST_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_dec[AW-1:0];
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                wr_data    = rd_data_reg;
                idx_next   = idx_dec;
                state_next = (idx_dec > lo_reg) ? ST_SHIFT_RD : ST_PLACE;
            end
            ST_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg[AW-1:0];
                wr_data    = req_reg;
                count_next = count_reg + ONE_C;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = stat_reg;
                    out_present_next = eq_reg;
                    out_pos_next     = lo_reg;
                    out_count_next   = count_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state, datapath and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            idx_reg         <= '0;
            eq_reg          <= 1'b0;
            op_reg          <= OP_INSERT;
            req_reg         <= '0;
            stat_reg        <= STATUS_DONE;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= STATUS_DONE;
            out_present_reg <= 1'b0;
            out_pos_reg     <= '0;
            out_count_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            idx_reg         <= idx_next;
            eq_reg          <= eq_next;
            op_reg          <= op_next;
            req_reg         <= req_next;
            stat_reg        <= stat_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_present_reg <= out_present_next;
            out_pos_reg     <= out_pos_next;
            out_count_reg   <= out_count_next;
        end
    end

    // positions and counts are reported modulo 128
    assign pos_ext = {{OUT_POS_W{1'b0}}, out_pos_reg};
    assign cnt_ext = {{OUT_POS_W{1'b0}}, out_count_reg};

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign present       = out_present_reg;
    assign slot_position = pos_ext[OUT_POS_W-1:0];
    assign entry_count   = cnt_ext[OUT_POS_W-1:0];

endmodule
